// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl files
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define WPES_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define WPES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/wpes_pkg.sv -----
// types and constants of the worst peer eviction selector
// no dependencies; used by every module of the block
package wpes_pkg;

   localparam int PEER_SLOTS = 8;
   localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int POS_W = $clog2(PEER_SLOTS + 1);

   localparam logic [15:0] SEV_TOP = 16'hFFFF;

   localparam logic [7:0] TH_MISS = 8'd4;
   localparam logic [7:0] TH_FALSE = 8'd8;
   localparam logic [7:0] TH_JITTER = 8'd10;
   localparam logic [7:0] TH_PANIC = 8'd8;

   // ceil(2^18 / 5) for floor(x / 5) with x below 2^15
   localparam logic [15:0] JIT_RECIP = 16'd52429;

   typedef struct packed {
      logic       slot_active;
      logic       slot_populated;
      logic [7:0] miss_count;
      logic [7:0] falseticker_count;
      logic [7:0] jitter_count;
      logic [7:0] panic_count;
      logic       last_slot;
   } req_item_type;

   typedef struct packed {
      logic        found;
      logic [2:0]  worst_slot;
      logic [15:0] chosen_severity;
   } rsp_item_type;

   typedef struct packed {
      logic        inactive_hit;
      logic        eligible;
      logic [15:0] severity;
   } candidate_type;

endpackage

// ----- src/wpes_score.sv -----
// scores one peer-slot request: eligibility and severity
// depends on wpes_pkg
module wpes_score (
   input  wpes_pkg::req_item_type  item,
   output wpes_pkg::candidate_type cand
);

   logic [14:0] jit_scaled;
   logic [30:0] jit_prod;
   logic [12:0] jit_term;
   logic [15:0] sum;

   always_comb begin
      jit_scaled = {item.jitter_count, 7'b0};
      jit_prod = 31'(jit_scaled) * 31'(wpes_pkg::JIT_RECIP);
      jit_term = jit_prod[30:18];
      sum = {2'b0, item.miss_count, 6'b0}
          + {3'b0, item.falseticker_count, 5'b0}
          + {3'b0, jit_term}
          + {3'b0, item.panic_count, 5'b0};
      cand.inactive_hit = !item.slot_active && item.slot_populated;
      cand.eligible = item.slot_active &&
                      ((item.miss_count >= wpes_pkg::TH_MISS) ||
                       (item.falseticker_count >= wpes_pkg::TH_FALSE) ||
                       (item.jitter_count >= wpes_pkg::TH_JITTER) ||
                       (item.panic_count >= wpes_pkg::TH_PANIC));
      cand.severity = sum;
   end

endmodule

// ----- src/wpes_track.sv -----
// running best-slot state of a scan and the result it gives on the last slot
// depends on wpes_pkg
module wpes_track (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    last,
   input  wpes_pkg::candidate_type cand,
   output wpes_pkg::rsp_item_type  result
);

   logic [wpes_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [15:0]                best_sev_ff, best_sev_in;
   logic [wpes_pkg::IDX_W-1:0] best_idx_ff, best_idx_in;
   logic                       best_valid_ff, best_valid_in;

   logic                       in_range;
   logic                       take;
   logic [wpes_pkg::IDX_W+2:0] idx_ext;

   always_comb begin
      in_range = pos_ff < wpes_pkg::POS_W'(wpes_pkg::PEER_SLOTS);
      take = in_range &&
             ((cand.inactive_hit && (best_sev_ff < wpes_pkg::SEV_TOP)) ||
              (cand.eligible && (cand.severity > best_sev_ff)));
      pos_in = in_range ? pos_ff + 1'b1 : pos_ff;
      best_sev_in = best_sev_ff;
      best_idx_in = best_idx_ff;
      best_valid_in = best_valid_ff;
      if (take) begin
         best_sev_in = cand.inactive_hit ? wpes_pkg::SEV_TOP : cand.severity;
         best_idx_in = pos_ff[wpes_pkg::IDX_W-1:0];
         best_valid_in = 1'b1;
      end
      idx_ext = {3'b0, best_idx_in};
      result.found = best_valid_in;
      result.worst_slot = best_valid_in ? idx_ext[2:0] : 3'd0;
      result.chosen_severity = best_valid_in ? best_sev_in : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && last)) begin
         pos_ff <= '0;
         best_sev_ff <= '0;
         best_idx_ff <= '0;
         best_valid_ff <= 1'b0;
      end else if (advance) begin
         pos_ff <= pos_in;
         best_sev_ff <= best_sev_in;
         best_idx_ff <= best_idx_in;
         best_valid_ff <= best_valid_in;
      end
   end

endmodule

// ----- src/worst_peer_eviction_selector_core.sv -----
// top level of the worst peer eviction selector: input and result registers
// depends on wpes_pkg, wpes_score, wpes_track and assert_macros.svh
//
// Usage:
// - req channel: one peer-slot record per request, in slot order; last_slot
//   marks the final slot of a scan. Slots past PEER_SLOTS in one scan are
//   ignored until a request marked last arrives.
// - rsp channel: one result per scan, produced by the request marked last:
//   found, worst_slot, chosen_severity (65535 marks a populated inactive slot).
// - Throughput: one request per cycle, sustained unless a last request waits behind
//   a stalled result. The whole scoring and compare for a slot sits between the
//   input register and the running state. A last request's result goes from the
//   tracker into the result register, which drives rsp_valid and rsp_item.
// - Stall: rsp_stall holds the result register. Non-last requests keep
//   flowing; req_stall rises only when a last request waits in the input
//   register behind a stalled result.
// - Reset: synchronous, active high; clears the scan state and both valids.
`include "assert_macros.svh"

module worst_peer_eviction_selector_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  wpes_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wpes_pkg::rsp_item_type rsp_item
);

   logic                    stage_valid_ff, stage_valid_in;
   wpes_pkg::req_item_type  stage_item_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   wpes_pkg::rsp_item_type  rsp_item_ff;

   logic                    out_free;
   logic                    stage_adv;
   logic                    emit;
   wpes_pkg::candidate_type cand;
   wpes_pkg::rsp_item_type  result;

   wpes_score u_score (
      .item (stage_item_ff),
      .cand (cand)
   );

   wpes_track u_track (
      .clock   (clock),
      .reset   (reset),
      .advance (stage_adv),
      .last    (stage_item_ff.last_slot),
      .cand    (cand),
      .result  (result)
   );

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      stage_adv = stage_valid_ff && (!stage_item_ff.last_slot || out_free);
      emit = stage_adv && stage_item_ff.last_slot;
      req_stall = stage_valid_ff && !stage_adv;
      stage_valid_in = req_stall ? stage_valid_ff : req_valid;
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stage_item_ff <= req_item;
      end
      if (emit) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   `WPES_ASSERT_NOW(a_stall_cause, clock, reset, req_stall,
      stage_valid_ff && stage_item_ff.last_slot && rsp_valid_ff && rsp_stall)
   `WPES_ASSERT_NOW(a_rsp_origin, clock, reset, $rose(rsp_valid_ff),
      $past(stage_valid_ff && stage_item_ff.last_slot))
   `WPES_ASSERT_NOW(a_not_found_zero, clock, reset, rsp_valid_ff && !rsp_item_ff.found,
      (rsp_item_ff.worst_slot == 3'd0) && (rsp_item_ff.chosen_severity == 16'd0))
   `WPES_ASSERT_NEXT(a_emit_loads, clock, reset, emit, rsp_valid_ff)

endmodule
